// ===== hdl/rrla_pkg.sv =====
package rrla_pkg;

	localparam int FIFO_DEPTH    = 128;
	localparam int LINE_CAPACITY = 64;
	localparam int PTR_W         = $clog2(FIFO_DEPTH);
	localparam int LINE_DEPTH    = LINE_CAPACITY - 1;
	localparam int LIDX_W        = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int LEN_W         = $clog2(LINE_CAPACITY);
	localparam int QDEPTH        = 2;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	typedef struct packed {
		logic       func;
		logic [7:0] rx_byte;
	} in_t;

	typedef struct packed {
		logic       line_ready;
		logic       char_valid;
		logic [7:0] char_value;
		logic       last;
	} out_t;

	typedef enum logic {
		CMD_PUSH  = 1'b0,
		CMD_DRAIN = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CHECK,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_SINGLE
	} state_t;

endpackage

// ===== hdl/rrla_front.sv =====
module rrla_front import rrla_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  in_t  item,
	output logic cmd_valid,
	output cmd_t cmd,
	input  logic cmd_pop
);

	localparam logic [1:0] CNT_FULL = 2'(QDEPTH);

	cmd_t       q_mem_q [QDEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       cmd_in;
	logic       push;
	logic       pop;

	// classify the beat into a command
	always_comb begin
		cmd_in.kind = item.func ? CMD_DRAIN : CMD_PUSH;
		cmd_in.data = item.rx_byte;
	end

	assign item_ready = (cnt_q != CNT_FULL);
	assign push       = item_valid && item_ready;
	assign pop        = cmd_pop && cmd_valid;
	assign cmd_valid  = (cnt_q != 2'd0);
	assign cmd        = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hdl/rrla_back.sv =====
module rrla_back import rrla_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	output logic result_valid,
	input  logic result_ready,
	output out_t result
);

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
	localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
	localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(LINE_DEPTH);
	localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);

	logic [7:0]       fifo_mem [FIFO_DEPTH];
	logic [7:0]       line_mem [LINE_DEPTH];

	state_t           state_q, state_d;
	logic [PTR_W-1:0] wp_q, rp_q, wp_inc, rp_inc;
	logic [LEN_W-1:0] len_q, idx_q;
	logic [7:0]       fifo_data_q;
	logic [7:0]       line_data_q;
	logic             single_ready_q;
	logic             result_valid_q;
	out_t             result_q;

	logic fifo_empty, can_load, is_cr, is_lf, emit_last;
	logic push_ok, fifo_rd, line_wr, line_drop, line_rd, out_load;

	assign wp_inc     = (wp_q == PTR_LAST) ? '0 : wp_q + PTR_ONE;
	assign rp_inc     = (rp_q == PTR_LAST) ? '0 : rp_q + PTR_ONE;
	assign fifo_empty = (rp_q == wp_q);
	assign can_load   = !result_valid_q || result_ready;
	assign is_cr      = (fifo_data_q == CH_CR);
	assign is_lf      = (fifo_data_q == CH_LF);
	assign emit_last  = ((idx_q + LEN_ONE) == len_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && cmd.kind == CMD_DRAIN) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				state_d = fifo_empty ? ST_SINGLE : ST_CHECK;
			end
			ST_CHECK: begin
				if (is_lf) begin
					state_d = (len_q == '0) ? ST_SINGLE : ST_EMIT_RD;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				if (can_load) begin
					state_d = emit_last ? ST_IDLE : ST_EMIT_RD;
				end
			end
			ST_SINGLE: begin
				if (can_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control strobes
	always_comb begin
		cmd_pop   = 1'b0;
		push_ok   = 1'b0;
		fifo_rd   = 1'b0;
		line_wr   = 1'b0;
		line_drop = 1'b0;
		line_rd   = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd_pop = cmd_valid;
				push_ok = cmd_valid && cmd.kind == CMD_PUSH && wp_inc != rp_q;
			end
			ST_SCAN: begin
				fifo_rd = !fifo_empty;
			end
			ST_CHECK: begin
				line_wr   = !is_cr && !is_lf && len_q < LEN_MAX;
				line_drop = !is_cr && !is_lf && len_q == LEN_MAX;
			end
			ST_EMIT_RD: begin
				line_rd = 1'b1;
			end
			ST_EMIT_LD, ST_SINGLE: begin
				out_load = can_load;
			end
			default: begin
				cmd_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			fifo_mem[wp_q] <= cmd.data;
		end
		if (fifo_rd) begin
			fifo_data_q <= fifo_mem[rp_q];
		end
		if (line_wr) begin
			line_mem[len_q[LIDX_W-1:0]] <= fifo_data_q;
		end
		if (line_rd) begin
			line_data_q <= line_mem[idx_q[LIDX_W-1:0]];
		end
		if (out_load) begin
			if (state_q == ST_EMIT_LD) begin
				result_q.line_ready <= 1'b1;
				result_q.char_valid <= 1'b1;
				result_q.char_value <= line_data_q;
				result_q.last       <= emit_last;
			end else begin
				result_q.line_ready <= single_ready_q;
				result_q.char_valid <= 1'b0;
				result_q.char_value <= 8'h00;
				result_q.last       <= 1'b1;
			end
		end
		if (state_q == ST_SCAN && fifo_empty) begin
			single_ready_q <= 1'b0;
		end else if (state_q == ST_CHECK && is_lf) begin
			single_ready_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			wp_q           <= '0;
			rp_q           <= '0;
			len_q          <= '0;
			idx_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push_ok) begin
				wp_q <= wp_inc;
			end
			if (fifo_rd) begin
				rp_q <= rp_inc;
			end
			if (line_wr) begin
				len_q <= len_q + LEN_ONE;
			end else if (line_drop) begin
				len_q <= '0;
			end else if (state_q == ST_CHECK && is_lf) begin
				idx_q <= '0;
			end else if (out_load && state_q == ST_EMIT_LD) begin
				if (emit_last) begin
					len_q <= '0;
				end else begin
					idx_q <= idx_q + LEN_ONE;
				end
			end
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push_ok |=> (wp_q != rp_q))
		else $error("fifo empty right after an accepted push");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_MAX)
		else $error("line length beyond line store");

	a_emit_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_LD) |-> (len_q != '0 && idx_q < len_q))
		else $error("emit index outside the line");

	a_check_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> ($past(state_q) == ST_SCAN))
		else $error("byte check without a fifo read");

endmodule

// ===== hdl/rx_ring_buffer_line_assembler.sv =====
// Push beat: enters the command queue, written to the ring by the idle back; 1 per cycle if idle.
// Drain beat: each byte popped from the ring takes a registered ring read, then a classify,
// then each line character emitted takes a registered line store read, then an output load.
// No line feed or an empty line: the single result loads once the output register is free.
// Reset (arst_n low, async): queue, ring pointers, line length, state and output valid clear.
// Ring and line store contents are not cleared; only written entries are read.
module rx_ring_buffer_line_assembler import rrla_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  in_t  item,
	output logic result_valid,
	input  logic result_ready,
	output out_t result
);

	// command queue between the front and the back; the back pops one
	// command at a time and only while it is idle
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	// front: accept beats, classify push versus drain, hold them in a
	// two-entry queue so the sender sees ready while the back is busy
	rrla_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	// back: owns the byte ring (one slot kept empty, drop when full), the
	// line store and the result register; a drain walks the ring, drops CRs,
	// appends other bytes, clears an overflowing line and emits it on line feed
	rrla_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
